// File: hw/rtl/jswr_pkg.sv
// ----------------------------------------------------------------------------
// jswr_pkg
// Shared types and fixed widths of the joint stream watchdog ramp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jswr_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 5;
  localparam int POS_W   = 10;
  localparam int TICK_W  = 32;
  localparam int TMO_W   = 16;
  localparam int ELAP_W  = 10;
  localparam int PROD_W  = POS_W + ELAP_W;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [TMO_W-1:0] TMO_RESET = 16'd10;

  typedef enum logic [OP_W-1:0] {
    OP_CMD  = 2'd0,
    OP_SAFE = 2'd1,
    OP_GOAL = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SRC_TARGET = 2'd0,
    SRC_SAFE   = 2'd1,
    SRC_RAMP   = 2'd2
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  joint_index;
    logic [POS_W-1:0]  position;
    logic              last_element;
    logic [TICK_W-1:0] tick_count;
    logic              stream_mode;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_joint;
    logic [POS_W-1:0] goal_position;
    logic             last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/jswr_chan_if.sv
// ----------------------------------------------------------------------------
// jswr_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jswr_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/jswr_div.sv
// ----------------------------------------------------------------------------
// jswr_div
// Division by a fixed divisor through reciprocal multiplication; the quotient
// is registered and valid in the cycle after the request.
// ----------------------------------------------------------------------------
`default_nettype none

module jswr_div
  import jswr_pkg::*;
#(
  parameter int DIVISOR = 50
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int RECIP_W = PROD_W + 2;
  localparam int SCL_W   = PROD_W + RECIP_W;
  localparam int SHIFT   = PROD_W + $clog2(DIVISOR);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic              done_r, done_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [SCL_W-1:0]  scaled;

  assign scaled = SCL_W'(req.dividend) * SCL_W'(RECIP_C);

  always_comb begin
    done_nxt = req.start;
    quo_nxt  = quo_r;
    if (req.start) begin
      quo_nxt = PROD_W'(scaled >> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/joint_stream_watchdog_ramp_unit.sv
// ----------------------------------------------------------------------------
// joint_stream_watchdog_ramp_unit
// Servo joint stream supervisor with command timeout and ramp to safe pose.
//
//   channel | dir | handshake                    | beat
//   in_ch   | in  | valid/ready                  | in_beat_t (op, joint, pos, tick)
//   out_ch  | out | valid/ready, output register | out_beat_t (joint, goal, last)
//   apb     | in  | psel/penable/pwrite, pready  | stream_timeout_ticks at 0x0
//
// Command, safe-pose and goal beats are taken in IDLE without a stall. A tick
// that emits stored poses passes LOAD and OUT per joint; a ramp tick passes
// LOAD, DIV and OUT, waiting in DIV on the shared reciprocal-multiply divider.
// in_ch.ready is low from an accepted emitting tick until its last joint is
// loaded into the output register. A stalled out_ch holds the sequencer.
// Synchronous active-low reset; all pose stores reset to CENTER_POSITION.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_stream_watchdog_ramp_unit
  import jswr_pkg::*;
#(
  parameter int JOINTS          = 18,
  parameter int RAMP_TICKS      = 50,
  parameter int CENTER_POSITION = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  jswr_chan_if.sink         in_ch,
  jswr_chan_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JW-1:0]     LAST_J = JW'(JOINTS - 1);
  localparam logic [POS_W-1:0]  CENTER = POS_W'(CENTER_POSITION);
  localparam logic [TICK_W-1:0] RAMP_C = TICK_W'(RAMP_TICKS);

  logic [POS_W-1:0] target_r [JOINTS];
  logic [POS_W-1:0] origin_r [JOINTS];
  logic [POS_W-1:0] safe_r   [JOINTS];
  logic [POS_W-1:0] goals_r  [JOINTS];

  state_t            state_r, state_nxt;
  src_t              src_r, src_nxt;
  logic              latch_r, latch_nxt;
  logic [ELAP_W-1:0] elapsed_r, elapsed_nxt;
  logic [JW-1:0]     jnt_r, jnt_nxt;
  logic              active_r, active_nxt;
  logic              ramping_r, ramping_nxt;
  logic [TICK_W-1:0] last_cmd_r, last_cmd_nxt;
  logic [TICK_W-1:0] ramp_start_r, ramp_start_nxt;
  logic [TMO_W-1:0]  tmo_r, tmo_nxt;
  logic [POS_W-1:0]  res_r, res_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic              neg_r, neg_nxt;
  div_req_t          div_req_r, div_req_nxt;
  div_rsp_t          div_rsp;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  in_beat_t          ip;
  logic              in_ready;
  logic              in_fire;
  logic              idx_ok;
  logic [JW-1:0]     widx;
  logic              ld_out;
  logic              cfg_wr;
  logic [TICK_W-1:0] age;
  logic [TICK_W-1:0] el_full;
  logic [POS_W-1:0]  origin_rd;
  logic signed [POS_W:0] delta;
  logic [POS_W:0]    mag;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  quo;

  assign ip       = in_ch.payload;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign idx_ok   = ((IDX_W + 2)'(ip.joint_index) < (IDX_W + 2)'(JOINTS));
  assign widx     = JW'(ip.joint_index);
  assign ld_out   = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];

  assign age       = ip.tick_count - last_cmd_r;
  assign el_full   = ramping_r ? (ip.tick_count - ramp_start_r) : '0;
  assign origin_rd = latch_r ? goals_r[jnt_r] : origin_r[jnt_r];
  assign delta     = $signed({1'b0, safe_r[jnt_r]}) - $signed({1'b0, origin_rd});
  assign mag       = delta[POS_W] ? (~delta + (POS_W + 1)'(1)) : delta;
  assign prod      = PROD_W'(mag[POS_W-1:0]) * PROD_W'(elapsed_r);
  assign quo       = div_rsp.quotient[POS_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    src_nxt        = src_r;
    latch_nxt      = latch_r;
    elapsed_nxt    = elapsed_r;
    jnt_nxt        = jnt_r;
    active_nxt     = active_r;
    ramping_nxt    = ramping_r;
    last_cmd_nxt   = last_cmd_r;
    ramp_start_nxt = ramp_start_r;
    tmo_nxt        = tmo_r;
    res_nxt        = res_r;
    start_nxt      = start_r;
    neg_nxt        = neg_r;
    div_req_nxt    = '0;
    out_valid_nxt  = out_valid_r;
    out_beat_nxt   = out_beat_r;

    if (cfg_wr) begin
      tmo_nxt = pwdata[TMO_W-1:0];
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(ip.operation))
            OP_CMD: begin
              if (ip.last_element) begin
                last_cmd_nxt = ip.tick_count;
                active_nxt   = 1'b1;
                ramping_nxt  = 1'b0;
              end
            end
            OP_SAFE, OP_GOAL: begin
            end
            OP_TICK: begin
              if (!ip.stream_mode) begin
                active_nxt  = 1'b0;
                ramping_nxt = 1'b0;
              end else if (active_r) begin
                jnt_nxt   = '0;
                state_nxt = ST_LOAD;
                latch_nxt = 1'b0;
                if (!ramping_r && (age <= TICK_W'(tmo_r))) begin
                  src_nxt = SRC_TARGET;
                end else begin
                  if (!ramping_r) begin
                    ramp_start_nxt = ip.tick_count;
                    ramping_nxt    = 1'b1;
                    latch_nxt      = 1'b1;
                  end
                  if (el_full >= RAMP_C) begin
                    active_nxt  = 1'b0;
                    ramping_nxt = 1'b0;
                    src_nxt     = SRC_SAFE;
                  end else begin
                    src_nxt     = SRC_RAMP;
                    elapsed_nxt = el_full[ELAP_W-1:0];
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (src_r == SRC_RAMP) begin
          div_req_nxt.start    = 1'b1;
          div_req_nxt.dividend = prod;
          start_nxt            = origin_rd;
          neg_nxt              = delta[POS_W];
          state_nxt            = ST_DIV;
        end else begin
          res_nxt   = (src_r == SRC_SAFE) ? safe_r[jnt_r] : target_r[jnt_r];
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = neg_r ? (start_r - quo) : (start_r + quo);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (ld_out) begin
          out_valid_nxt              = 1'b1;
          out_beat_nxt.out_joint     = IDX_W'(jnt_r);
          out_beat_nxt.goal_position = res_r;
          out_beat_nxt.last_of_run   = (jnt_r == LAST_J);
          if (jnt_r == LAST_J) begin
            state_nxt = ST_IDLE;
          end else begin
            jnt_nxt   = jnt_r + JW'(1);
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_r        <= SRC_TARGET;
      latch_r      <= 1'b0;
      jnt_r        <= '0;
      active_r     <= 1'b0;
      ramping_r    <= 1'b0;
      last_cmd_r   <= '0;
      ramp_start_r <= '0;
      tmo_r        <= TMO_RESET;
      div_req_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      src_r        <= src_nxt;
      latch_r      <= latch_nxt;
      jnt_r        <= jnt_nxt;
      active_r     <= active_nxt;
      ramping_r    <= ramping_nxt;
      last_cmd_r   <= last_cmd_nxt;
      ramp_start_r <= ramp_start_nxt;
      tmo_r        <= tmo_nxt;
      div_req_r    <= div_req_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    elapsed_r  <= elapsed_nxt;
    res_r      <= res_nxt;
    start_r    <= start_nxt;
    neg_r      <= neg_nxt;
    out_beat_r <= out_beat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) begin
        target_r[i] <= CENTER;
        origin_r[i] <= CENTER;
        safe_r[i]   <= CENTER;
        goals_r[i]  <= CENTER;
      end
    end else begin
      if (in_fire && idx_ok) begin
        unique case (op_t'(ip.operation))
          OP_CMD:  target_r[widx] <= ip.position;
          OP_SAFE: safe_r[widx]   <= ip.position;
          OP_GOAL: goals_r[widx]  <= ip.position;
          OP_TICK: begin
          end
          default: begin
          end
        endcase
      end
      if ((state_r == ST_LOAD) && (src_r == SRC_RAMP) && latch_r) begin
        origin_r[jnt_r] <= origin_rd;
      end
      if (ld_out) begin
        goals_r[jnt_r] <= res_r;
      end
    end
  end

  jswr_div #(
    .DIVISOR (RAMP_TICKS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_beat_r;
  assign prdata         = paddr[2] ? '0 : CFG_DW'(tmo_r);
  assign pready         = 1'b1;

endmodule

`default_nettype wire

// File: hw/rtl/jswr_checker.sv
// ----------------------------------------------------------------------------
// jswr_checker
// Port-level checks of the joint stream watchdog ramp unit.
// ----------------------------------------------------------------------------
`default_nettype none

module jswr_checker
  import jswr_pkg::*;
#(
  parameter int JOINTS = 18
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [OP_W-1:0]  in_op,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_joint,
  input logic [POS_W-1:0] out_goal,
  input logic             out_last
);

  localparam logic [IDX_W+1:0] JOINTS_C = (IDX_W + 2)'(JOINTS);
  localparam logic [IDX_W+1:0] LAST_C   = (IDX_W + 2)'(JOINTS - 1);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_joint) &&
      $stable(out_goal) && $stable(out_last))
    else $error("stalled result beat changed");

  a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> ({2'b00, out_joint} == LAST_C))
    else $error("last_of_run on a joint other than the final one");

  a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, out_joint} < JOINTS_C))
    else $error("result joint out of range");

  a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_TICK) |=> in_ready)
    else $error("store write beat stalled the input");

endmodule

bind joint_stream_watchdog_ramp_unit jswr_checker #(
  .JOINTS (JOINTS)
) u_jswr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.payload.operation),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_joint (out_ch.payload.out_joint),
  .out_goal  (out_ch.payload.goal_position),
  .out_last  (out_ch.payload.last_of_run)
);

`default_nettype wire

// File: sim/tb_joint_stream_watchdog_ramp_unit.sv
// ----------------------------------------------------------------------------
// tb_joint_stream_watchdog_ramp_unit
// Self-checking bench for the joint stream watchdog ramp unit. Command,
// safe-pose, goal and tick beats go in with random gaps. The result channel
// stalls at random. An in-bench model of the timeout, the linear ramp and the
// safe pose predicts every joint goal, and the goals are checked in order.
// The timeout register is written and read back over APB between phases.
// ----------------------------------------------------------------------------
module tb_joint_stream_watchdog_ramp_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import jswr_pkg::*;

  localparam int JOINTS      = 18;
  localparam int RAMP_TICKS  = 50;
  localparam int CENTER      = 512;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BEATS = 270;
  localparam int SETTLE      = 40;
  localparam logic [CFG_AW-1:0] ADDR_TIMEOUT = '0;

  typedef logic [JOINTS-1:0][POS_W-1:0] pose_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  jswr_chan_if #(.payload_t(in_beat_t))  in_ch ();
  jswr_chan_if #(.payload_t(out_beat_t)) out_ch ();

  joint_stream_watchdog_ramp_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pose_t       tgt_pose;
  pose_t       origin_pose;
  pose_t       safe_tbl;
  pose_t       goal_pose;
  logic        stream_on;
  logic        ramp_on;
  logic [31:0] cmd_tick;
  logic [31:0] ramp_tick0;
  logic [15:0] timeout_ticks;

  out_beat_t pending_goals[$];

  int mismatches;
  int beats_sent;
  int goals_checked;
  int ramp_steps;
  int timeout_writes;
  int cycle_count;
  int stall_left;
  bit idle_en;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void reset_model();
    for (int j = 0; j < JOINTS; j++) begin
      tgt_pose[j]    = POS_W'(CENTER);
      origin_pose[j] = POS_W'(CENTER);
      safe_tbl[j]    = POS_W'(CENTER);
      goal_pose[j]   = POS_W'(CENTER);
    end
    stream_on     = 1'b0;
    ramp_on       = 1'b0;
    cmd_tick      = '0;
    ramp_tick0    = '0;
    timeout_ticks = TMO_RESET;
  endfunction

  function automatic void emit_pose(input pose_t p);
    out_beat_t g;
    for (int j = 0; j < JOINTS; j++) begin
      goal_pose[j]    = p[j];
      g.out_joint     = IDX_W'(j);
      g.goal_position = p[j];
      g.last_of_run   = (j == JOINTS - 1);
      pending_goals.push_back(g);
    end
  endfunction

  function automatic void apply_beat(input in_beat_t b);
    pose_t       ramp_pose;
    logic [31:0] elapsed;
    int          start;
    int          delta;
    int          v;
    logic        idx_ok;
    idx_ok = (b.joint_index < JOINTS);
    case (op_t'(b.operation))
      OP_CMD: begin
        if (idx_ok) tgt_pose[b.joint_index] = b.position;
        if (b.last_element) begin
          cmd_tick  = b.tick_count;
          stream_on = 1'b1;
          ramp_on   = 1'b0;
        end
      end
      OP_SAFE: begin
        if (idx_ok) safe_tbl[b.joint_index] = b.position;
      end
      OP_GOAL: begin
        if (idx_ok) goal_pose[b.joint_index] = b.position;
      end
      OP_TICK: begin
        if (!b.stream_mode) begin
          stream_on = 1'b0;
          ramp_on   = 1'b0;
        end else if (stream_on) begin
          if (!ramp_on && (b.tick_count - cmd_tick) <= timeout_ticks) begin
            emit_pose(tgt_pose);
          end else begin
            if (!ramp_on) begin
              origin_pose = goal_pose;
              ramp_tick0  = b.tick_count;
              ramp_on     = 1'b1;
            end
            elapsed = b.tick_count - ramp_tick0;
            if (elapsed >= RAMP_TICKS) begin
              stream_on = 1'b0;
              ramp_on   = 1'b0;
              emit_pose(safe_tbl);
            end else begin
              for (int j = 0; j < JOINTS; j++) begin
                start        = int'(origin_pose[j]);
                delta        = int'(safe_tbl[j]) - start;
                v            = start + (delta * int'(elapsed)) / RAMP_TICKS;
                ramp_pose[j] = v[POS_W-1:0];
              end
              ramp_steps++;
              emit_pose(ramp_pose);
            end
          end
        end
      end
    endcase
  endfunction

  task automatic send_beat(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [POS_W-1:0] pos, input logic last,
                           input logic [31:0] tick, input logic smode);
    in_beat_t b;
    int       gap;
    b.operation    = op;
    b.joint_index  = idx;
    b.position     = pos;
    b.last_element = last;
    b.tick_count   = tick;
    b.stream_mode  = smode;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    do @(posedge clk); while (!in_ch.ready);
    apply_beat(b);
    beats_sent++;
  endtask

  task automatic send_cmd(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                          input logic last, input logic [31:0] tick);
    send_beat(OP_CMD, idx, pos, last, tick, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_store(input op_t op, input logic [IDX_W-1:0] idx,
                            input logic [POS_W-1:0] pos);
    send_beat(op, idx, pos, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick(input logic [31:0] tick, input logic smode);
    send_beat(OP_TICK, IDX_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 1023)),
              1'($urandom_range(0, 1)), tick, smode);
  endtask

  function automatic logic [IDX_W-1:0] pick_joint();
    if ($urandom_range(0, 7) == 0) return IDX_W'($urandom_range(JOINTS, 31));
    return IDX_W'($urandom_range(0, JOINTS - 1));
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_goals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    logic [CFG_DW-1:0] rd;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TIMEOUT;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    timeout_ticks = value;
    timeout_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[TMO_W-1:0] !== value)
      report_mismatch($sformatf("timeout readback %0h, wrote %0h", rd[TMO_W-1:0], value));
  endtask

  task automatic test_directed_edges();
    idle_en = 1'b1;
    send_tick(32'h0000_0000, 1'b1);
    send_store(OP_SAFE, 5'd0, 10'd1023);
    send_store(OP_SAFE, 5'd17, 10'd0);
    send_store(OP_SAFE, 5'd31, 10'd0);
    send_store(OP_GOAL, 5'd5, 10'd0);
    send_store(OP_GOAL, 5'd17, 10'd1023);
    send_store(OP_GOAL, 5'd18, 10'd1023);
    send_cmd(5'd0, 10'd0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(5'd17, 10'd1023, 1'b0, 32'h0000_0000);
    send_cmd(5'd31, 10'd1023, 1'b1, 32'hFFFF_FFF8);
    send_tick(32'h0000_0002, 1'b1);
    send_tick(32'h0000_0003, 1'b1);
    send_store(OP_GOAL, 5'd3, 10'd100);
    send_tick(32'h0000_0004, 1'b1);
    send_tick(32'h0000_0028, 1'b1);
    send_tick(32'h0000_0034, 1'b1);
    send_tick(32'h0000_0035, 1'b1);
    send_tick(32'h0000_0036, 1'b1);
    send_cmd(5'd2, 10'd700, 1'b1, 32'h8000_0000);
    send_tick(32'h8000_0000, 1'b0);
    send_tick(32'h8000_0001, 1'b1);
    send_cmd(5'd4, 10'd300, 1'b1, 32'h1234_0000);
    send_tick(32'h1234_0005, 1'b1);
    send_tick(32'h1234_0020, 1'b1);
    send_cmd(5'd4, 10'd301, 1'b1, 32'h1234_0021);
    send_tick(32'h1234_0022, 1'b1);
    wait_idle();
  endtask

  task automatic test_timeout_extremes();
    logic [31:0] t;
    idle_en = 1'b0;
    write_timeout(16'd0);
    t = $urandom;
    send_cmd(pick_joint(), POS_W'($urandom), 1'b1, t);
    send_tick(t, 1'b1);
    send_tick(t + 1, 1'b1);
    send_tick(t + 1 + RAMP_TICKS, 1'b1);
    write_timeout(16'hFFFF);
    t = $urandom;
    send_cmd(pick_joint(), POS_W'($urandom), 1'b1, t);
    send_tick(t + 32'd65535, 1'b1);
    send_tick(t + 32'd65536, 1'b1);
    send_tick(t + 32'd65561, 1'b1);
    send_tick(t + 32'd65562, 1'b0);
    write_timeout(16'd1);
  endtask

  task automatic run_stream();
    logic [31:0] t;
    logic [31:0] rs;
    int          n;
    int          e;
    repeat ($urandom_range(0, 3))
      send_beat(op_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 31)),
                POS_W'($urandom), 1'($urandom_range(0, 1)), $urandom,
                1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 4))
      send_store($urandom_range(0, 1) ? OP_SAFE : OP_GOAL, pick_joint(), POS_W'($urandom));
    t = $urandom;
    n = $urandom_range(1, JOINTS);
    for (int j = 0; j < n; j++)
      send_cmd(pick_joint(), POS_W'($urandom), (j == n - 1), (j == n - 1) ? t : $urandom);
    repeat ($urandom_range(0, 3))
      send_tick(t + $urandom_range(0, timeout_ticks), 1'b1);
    if ($urandom_range(0, 5) == 0) begin
      send_tick($urandom, 1'b0);
      send_tick(t, 1'b1);
    end else begin
      rs = t + timeout_ticks + 1 + $urandom_range(0, 2);
      send_tick(rs, 1'b1);
      e = 0;
      while (e < RAMP_TICKS) begin
        e += $urandom_range(1, 15);
        if ($urandom_range(0, 9) == 0)
          send_store($urandom_range(0, 1) ? OP_SAFE : OP_GOAL, pick_joint(),
                     POS_W'($urandom));
        if ($urandom_range(0, 11) == 0) begin
          send_cmd(pick_joint(), POS_W'($urandom), 1'b1, rs + e);
          e = RAMP_TICKS;
        end else begin
          send_tick(rs + e, 1'b1);
        end
      end
    end
  endtask

  task automatic test_random_streams();
    int stop_at;
    int seq;
    stop_at = beats_sent + RANDOM_BEATS;
    seq = 0;
    while (beats_sent < stop_at) begin
      if (seq % 4 == 3) begin
        case ($urandom_range(0, 4))
          0:       write_timeout(16'd0);
          1:       write_timeout(16'hFFFF);
          2:       write_timeout(16'($urandom));
          default: write_timeout(16'($urandom_range(1, 30)));
        endcase
      end
      idle_en = ($urandom_range(0, 3) != 0);
      run_stream();
      seq++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d goals pending", cycle_count,
               pending_goals.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        stall_left = idle_en ? $urandom_range(0, 10) : 0;
      else if (stall_left > 0)
        stall_left--;
      out_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_goals.size() == 0) begin
        report_mismatch($sformatf("unexpected goal joint %0d pos %0d",
                                  out_ch.payload.out_joint, out_ch.payload.goal_position));
      end else begin
        want = pending_goals.pop_front();
        goals_checked++;
        if (out_ch.payload.out_joint !== want.out_joint)
          report_mismatch($sformatf("out_joint %0d, want %0d",
                                    out_ch.payload.out_joint, want.out_joint));
        if (out_ch.payload.goal_position !== want.goal_position)
          report_mismatch($sformatf("joint %0d goal %0d, want %0d", want.out_joint,
                                    out_ch.payload.goal_position, want.goal_position));
        if (out_ch.payload.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("joint %0d last_of_run %0b, want %0b", want.out_joint,
                                    out_ch.payload.last_of_run, want.last_of_run));
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_en       = 1'b0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_timeout_extremes();
    test_random_streams();
    wait_idle();
    $display("Run covered %0d input beats, %0d joint goals checked, %0d ramp steps,",
             beats_sent, goals_checked, ramp_steps);
    $display("and %0d timeout register settings including 0 and 65535.", timeout_writes);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
